### rtl/core/fixed_block_pool_allocator_macros.svh
// ---------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FBPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBPA_ASSERT(label, clk, rst, prop, msg)
`define FBPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/core/fbpa_pkg.sv
// ---------------------------------------------------------------------------
// Fixed block pool allocator package
// Item types, operation and status codes, register indexes and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

   localparam int ADDR_W     = 32;
   localparam int BYTES_W    = 16;
   localparam int COUNT_W    = 11;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd4096;
   localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 16'd64;
   localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = 11'd1000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic                init;
      logic                pop;
      logic                take;
      logic                mult;
      logic                mult_count;
      logic                div_start;
      logic                push;
      logic                rsp_load;
      logic                rsp_grant;
      logic [STATUS_W-1:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              depth_nz;
      logic              untouched_nz;
      logic              addr_null;
      logic              outside;
      logic              div_done;
      logic              rem_nz;
      logic              full;
   } stat_type;

endpackage

`default_nettype wire

### rtl/core/fbpa_divider.sv
// ---------------------------------------------------------------------------
// Fixed block pool allocator divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]     dividend,
   input  wire logic [fbpa_pkg::BYTES_W-1:0]    divisor,
   output logic      [fbpa_pkg::ADDR_W-1:0]     quotient,
   output logic      [fbpa_pkg::BYTES_W-1:0]    remainder,
   output logic                                 done
);

   logic                              busy_ff,  busy_in;
   logic                              done_ff,  done_in;
   logic [fbpa_pkg::DIV_CNT_W-1:0]    step_ff,  step_in;
   logic [fbpa_pkg::ADDR_W-1:0]       quo_ff,   quo_in;
   logic [fbpa_pkg::BYTES_W-1:0]      rem_ff,   rem_in;
   logic [fbpa_pkg::BYTES_W-1:0]      dvs_ff,   dvs_in;
   logic [fbpa_pkg::BYTES_W:0]        shifted;
   logic [fbpa_pkg::BYTES_W:0]        diff;
   logic                              ge;

   assign shifted = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[fbpa_pkg::ADDR_W-2:0], ge};
         rem_in  = ge ? diff[fbpa_pkg::BYTES_W-1:0] : shifted[fbpa_pkg::BYTES_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   `FBPA_ASSERT(a_div_rem_bound, clock, reset, (done_ff |-> (rem_ff < dvs_ff)), "remainder not below divisor")
   `FBPA_ASSERT(a_div_no_restart, clock, reset, (start |-> !busy_ff), "divider restarted while busy")
   `FBPA_ASSERT(a_div_done_after_busy, clock, reset, ($rose(done_ff) |-> $past(busy_ff)), "done without a run")

endmodule

`default_nettype wire

### rtl/core/fbpa_datapath.sv
// ---------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Registers, free stack memory, counters, address multiplier, range
// check, divider and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_datapath #(
   parameter int MAX_BLOCKS = 1024,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]       csr_data,
   input  wire fbpa_pkg::req_type                 req_data,
   input  wire fbpa_pkg::cmd_type                 cmd,
   output fbpa_pkg::stat_type                     stat,
   output fbpa_pkg::rsp_type                      rsp_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;
   localparam int MUL_W = CNT_W + fbpa_pkg::BYTES_W;
   localparam int END_W = ((MUL_W > fbpa_pkg::ADDR_W) ? MUL_W : fbpa_pkg::ADDR_W) + 1;
   localparam logic [fbpa_pkg::ADDR_W-1:0] OUT_MASK = (ADDR_WIDTH >= fbpa_pkg::ADDR_W) ?
      {fbpa_pkg::ADDR_W{1'b1}} : fbpa_pkg::ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   logic [fbpa_pkg::ADDR_W-1:0]    pool_base_ff;
   logic [fbpa_pkg::BYTES_W-1:0]   block_bytes_ff;
   logic [fbpa_pkg::COUNT_W-1:0]   block_count_ff;

   logic [fbpa_pkg::FUNC_W-1:0]    func_ff;
   logic [fbpa_pkg::ADDR_W-1:0]    addr_ff;
   logic [CNT_W-1:0]               depth_ff, depth_in;
   logic [CNT_W-1:0]               untouched_ff, untouched_in;
   logic [IDX_W-1:0]               stack_mem [MAX_BLOCKS];
   logic [IDX_W-1:0]               rd_data_ff;
   logic [IDX_W-1:0]               idx_ff;
   logic                           from_stack_ff;
   logic [MUL_W-1:0]               product_ff;
   logic [fbpa_pkg::ADDR_W-1:0]    rsp_addr_ff;
   logic [fbpa_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic [CMP_W-1:0]               count_ext;
   logic [CNT_W-1:0]               eff_count;
   logic [CNT_W-1:0]               depth_dec;
   logic [CNT_W-1:0]               mul_op;
   logic [END_W-1:0]               pool_end;
   logic [fbpa_pkg::ADDR_W-1:0]    offset;
   logic [fbpa_pkg::ADDR_W-1:0]    grant_sum;
   logic [fbpa_pkg::ADDR_W-1:0]    quotient;
   logic [fbpa_pkg::BYTES_W-1:0]   remainder;
   logic                           div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= fbpa_pkg::RST_POOL_BASE;
         block_bytes_ff <= fbpa_pkg::RST_BLOCK_BYTES;
         block_count_ff <= fbpa_pkg::RST_BLOCK_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            fbpa_pkg::CSR_POOL_BASE:   pool_base_ff   <= csr_data;
            fbpa_pkg::CSR_BLOCK_BYTES: block_bytes_ff <= csr_data[fbpa_pkg::BYTES_W-1:0];
            fbpa_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_data[fbpa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign count_ext = CMP_W'(block_count_ff);
   assign eff_count = (count_ext > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(count_ext);
   assign depth_dec = depth_ff - 1'b1;

   always_comb begin
      depth_in     = depth_ff;
      untouched_in = untouched_ff;
      if (cmd.init) begin
         depth_in     = '0;
         untouched_in = eff_count;
      end
      if (cmd.pop) begin
         depth_in = depth_dec;
      end
      if (cmd.take) begin
         untouched_in = untouched_ff - 1'b1;
      end
      if (cmd.push) begin
         depth_in = depth_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         untouched_ff <= '0;
      end else begin
         depth_ff     <= depth_in;
         untouched_ff <= untouched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= quotient[IDX_W-1:0];
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[depth_dec[IDX_W-1:0]];
      end
   end

   assign mul_op = cmd.mult_count ? eff_count :
                   (from_stack_ff ? CNT_W'(rd_data_ff) : CNT_W'(idx_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         addr_ff <= req_data.block_address;
      end
      if (cmd.pop || cmd.take) begin
         from_stack_ff <= cmd.pop;
         idx_ff        <= untouched_in[IDX_W-1:0];
      end
      if (cmd.mult) begin
         product_ff <= MUL_W'(mul_op) * MUL_W'(block_bytes_ff);
      end
      if (cmd.rsp_load) begin
         rsp_addr_ff   <= cmd.rsp_grant ? (grant_sum & OUT_MASK) : '0;
         rsp_status_ff <= cmd.rsp_code;
      end
   end

   assign grant_sum = pool_base_ff + fbpa_pkg::ADDR_W'(product_ff);
   assign pool_end  = END_W'(pool_base_ff) + END_W'(product_ff);
   assign offset    = addr_ff - pool_base_ff;

   fbpa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (offset),
      .divisor   (block_bytes_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   always_comb begin
      stat.func         = func_ff;
      stat.depth_nz     = depth_ff != '0;
      stat.untouched_nz = untouched_ff != '0;
      stat.addr_null    = addr_ff == '0;
      stat.outside      = (addr_ff < pool_base_ff) || (END_W'(addr_ff) >= pool_end);
      stat.div_done     = div_done;
      stat.rem_nz       = remainder != '0;
      stat.full         = ((CNT_W+1)'(untouched_ff) + (CNT_W+1)'(depth_ff) >=
                           (CNT_W+1)'(eff_count)) || (depth_ff >= CNT_W'(MAX_BLOCKS));
   end

   assign rsp_data.granted_address = rsp_addr_ff;
   assign rsp_data.status          = rsp_status_ff;

   `FBPA_ASSERT(a_pool_bound, clock, reset, (((CNT_W+1)'(untouched_ff) + (CNT_W+1)'(depth_ff)) <= (CNT_W+1)'(MAX_BLOCKS)), "free list exceeds capacity")

endmodule

`default_nettype wire

### rtl/core/fbpa_ctrl.sv
// ---------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences one item through decode and, as its function needs, multiply,
// range check and divide, and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire fbpa_pkg::stat_type  stat,
   output fbpa_pkg::cmd_type        cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_MULT   = 6'b000100,
      S_RANGE  = 6'b001000,
      S_DIVIDE = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::STATUS_W-1:0]   code_ff, code_in;
   logic                            grant_ff, grant_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      code_in      = code_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.rsp_code  = code_ff;
      cmd.rsp_grant = grant_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            code_in  = fbpa_pkg::ST_OK;
            grant_in = 1'b0;
            unique case (stat.func)
               fbpa_pkg::FUNC_INIT: begin
                  cmd.init = 1'b1;
                  state_in = S_FINISH;
               end
               fbpa_pkg::FUNC_ALLOC: begin
                  if (stat.depth_nz) begin
                     cmd.pop  = 1'b1;
                     grant_in = 1'b1;
                     state_in = S_MULT;
                  end else if (stat.untouched_nz) begin
                     cmd.take = 1'b1;
                     grant_in = 1'b1;
                     state_in = S_MULT;
                  end else begin
                     code_in  = fbpa_pkg::ST_EMPTY;
                     state_in = S_FINISH;
                  end
               end
               fbpa_pkg::FUNC_FREE: begin
                  state_in = S_MULT;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MULT: begin
            cmd.mult       = 1'b1;
            cmd.mult_count = !grant_ff;
            state_in       = grant_ff ? S_FINISH : S_RANGE;
         end
         S_RANGE: begin
            if (stat.addr_null) begin
               code_in  = fbpa_pkg::ST_NULL;
               state_in = S_FINISH;
            end else if (stat.outside) begin
               code_in  = fbpa_pkg::ST_OUTSIDE;
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (stat.div_done) begin
               if (stat.rem_nz) begin
                  code_in = fbpa_pkg::ST_MISALIGNED;
               end else if (stat.full) begin
                  code_in = fbpa_pkg::ST_FULL;
               end else begin
                  cmd.push = 1'b1;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         code_ff      <= fbpa_pkg::ST_OK;
         grant_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
         grant_ff     <= grant_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `FBPA_ASSERT(a_no_result_overwrite, clock, reset, (!(cmd.rsp_load && rsp_valid_ff && rsp_stall)), "waiting item overwritten")
   `FBPA_ASSERT_ALWAYS(a_idle_after_reset, clock, (reset |=> (state_ff == S_IDLE && !rsp_valid_ff)), "controller not idle after reset")

endmodule

`default_nettype wire

### rtl/core/fixed_block_pool_allocator.sv
// Accept to result: free goes through multiply, range check and the 32-step divider,
// stopping after the range check when the address is null or outside the pool; alloc goes
// through multiply unless the pool is empty; init and no-op go straight to the result.
// One item in flight; the next item is accepted the cycle after the result is registered.
// A finished item waits in the output register while the next one is accepted.
// Reset (synchronous): registers take their defaults, the pool is empty until init.
// ---------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free-list allocator over a pool of equal blocks: init, alloc, free.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 1024,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire fbpa_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output fbpa_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]       csr_data
);

   fbpa_pkg::cmd_type   cmd;
   fbpa_pkg::stat_type  stat;
   logic                csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/fixed_block_pool_allocator_test.sv
// ---------------------------------------------------------------------------
// Fixed block pool allocator regression
// Drives init, alloc, free and no-op items through the request channel. A
// directed table, with its own expected responses, covers reset state, pool
// edges, status codes and register extremes; random phases under several pool
// settings and idle/stall patterns check against a local free-list predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fixed_block_pool_allocator_test;

   localparam int POOL_CAP      = 1024;
   localparam int DRAIN_CYCLES  = 48;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 250;
   localparam int NUM_PHASES    = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int END_WAIT      = 20000;
   localparam int MAX_PRINTS    = 40;

   localparam logic [fbpa_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum {ROW_OP, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic [1:0]                  code;
      logic [fbpa_pkg::ADDR_W-1:0] value;
      bit                          typed;
      fbpa_pkg::rsp_type           want;
   } dir_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   fbpa_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   fbpa_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fbpa_pkg::ADDR_W-1:0]    csr_data = '0;

   // predictor state
   logic [fbpa_pkg::ADDR_W-1:0]  cfg_base  = fbpa_pkg::RST_POOL_BASE;
   logic [fbpa_pkg::BYTES_W-1:0] cfg_bytes = fbpa_pkg::RST_BLOCK_BYTES;
   logic [fbpa_pkg::COUNT_W-1:0] cfg_count = fbpa_pkg::RST_BLOCK_COUNT;
   logic [9:0]                   free_stack [POOL_CAP];
   logic [10:0]                  free_depth = '0;
   logic [10:0]                  fresh_left = '0;

   fbpa_pkg::rsp_type           grant_queue [$];
   logic [fbpa_pkg::ADDR_W-1:0] held_addrs [$];

   bit                use_typed = 1'b0;
   fbpa_pkg::rsp_type typed_want = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int mismatches    = 0;
   int items_accepted = 0;
   int results_seen  = 0;
   int settings_run  = 0;
   int cycle_count   = 0;
   int status_seen [8];

   fixed_block_pool_allocator #(
      .MAX_BLOCKS(POOL_CAP),
      .ADDR_WIDTH(fbpa_pkg::ADDR_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses pending",
                  cycle_count, grant_queue.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what,
                                  input logic [fbpa_pkg::ADDR_W-1:0] got,
                                  input logic [fbpa_pkg::ADDR_W-1:0] want);
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH cycle %0d %s: got 0x%08h expected 0x%08h",
                  cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic logic [fbpa_pkg::COUNT_W-1:0] usable_blocks();
      return (cfg_count > POOL_CAP) ? fbpa_pkg::COUNT_W'(POOL_CAP) : cfg_count;
   endfunction

   function automatic logic [fbpa_pkg::ADDR_W-1:0] block_addr(input int unsigned idx);
      return cfg_base + fbpa_pkg::ADDR_W'(idx) * fbpa_pkg::ADDR_W'(cfg_bytes);
   endfunction

   function automatic fbpa_pkg::rsp_type pool_apply_op(input fbpa_pkg::req_type item);
      fbpa_pkg::rsp_type            res;
      logic [fbpa_pkg::COUNT_W-1:0] cnt;
      logic [9:0]                   idx;
      logic [47:0]                  pool_end;
      logic [fbpa_pkg::ADDR_W-1:0]  off;
      res.granted_address = '0;
      res.status = fbpa_pkg::ST_OK;
      cnt = usable_blocks();
      case (item.func)
         fbpa_pkg::FUNC_INIT: begin
            fresh_left = cnt;
            free_depth = '0;
         end
         fbpa_pkg::FUNC_ALLOC: begin
            if (free_depth != 0) begin
               free_depth = free_depth - 1'b1;
               idx = free_stack[free_depth[9:0]];
               res.granted_address = block_addr(32'(idx));
            end else if (fresh_left != 0) begin
               fresh_left = fresh_left - 1'b1;
               idx = fresh_left[9:0];
               res.granted_address = block_addr(32'(idx));
            end else begin
               res.status = fbpa_pkg::ST_EMPTY;
            end
         end
         fbpa_pkg::FUNC_FREE: begin
            pool_end = 48'(cfg_base) + 48'(cfg_bytes) * 48'(cnt);
            if (item.block_address == '0) begin
               res.status = fbpa_pkg::ST_NULL;
            end else if (48'(item.block_address) < 48'(cfg_base) ||
                         48'(item.block_address) >= pool_end) begin
               res.status = fbpa_pkg::ST_OUTSIDE;
            end else begin
               off = item.block_address - cfg_base;
               if ((off % fbpa_pkg::ADDR_W'(cfg_bytes)) != 0) begin
                  res.status = fbpa_pkg::ST_MISALIGNED;
               end else if (12'(fresh_left) + 12'(free_depth) >= 12'(cnt) ||
                            free_depth >= POOL_CAP) begin
                  res.status = fbpa_pkg::ST_FULL;
               end else begin
                  free_stack[free_depth[9:0]] = 10'(off / fbpa_pkg::ADDR_W'(cfg_bytes));
                  free_depth = free_depth + 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      fbpa_pkg::rsp_type want;
      fbpa_pkg::rsp_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            status_seen[int'(rsp_data.status)]++;
            if (grant_queue.size() == 0) begin
               report_mismatch("response with none pending", rsp_data.granted_address, '0);
            end else begin
               want = grant_queue.pop_front();
               if (rsp_data.granted_address !== want.granted_address)
                  report_mismatch("granted_address", rsp_data.granted_address,
                                  want.granted_address);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", fbpa_pkg::ADDR_W'(rsp_data.status),
                                  fbpa_pkg::ADDR_W'(want.status));
            end
         end
         if (req_valid && !req_stall) begin
            items_accepted++;
            pred = pool_apply_op(req_data);
            if (req_data.func == fbpa_pkg::FUNC_INIT)
               held_addrs.delete();
            else if (req_data.func == fbpa_pkg::FUNC_ALLOC && pred.status == fbpa_pkg::ST_OK)
               held_addrs.push_back(pred.granted_address);
            grant_queue.push_back(use_typed ? typed_want : pred);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fbpa_pkg::CSR_POOL_BASE:   cfg_base  = csr_data;
               fbpa_pkg::CSR_BLOCK_BYTES: cfg_bytes = csr_data[fbpa_pkg::BYTES_W-1:0];
               fbpa_pkg::CSR_BLOCK_COUNT: cfg_count = csr_data[fbpa_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      int served = 0;
      int left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != served) begin
            served = hold_requests;
            left = LONG_HOLD;
         end
         if (left > 0) begin
            rsp_stall <= 1'b1;
            left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // entered and left just after a falling edge
   task automatic send_req(input logic [fbpa_pkg::FUNC_W-1:0] func,
                           input logic [fbpa_pkg::ADDR_W-1:0] addr);
      fbpa_pkg::req_type item;
      item.func = func;
      item.block_address = addr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_pool();
      req_valid <= 1'b0;
      while (grant_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [fbpa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fbpa_pkg::ADDR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_pool(input logic [fbpa_pkg::ADDR_W-1:0] base,
                                 input logic [fbpa_pkg::BYTES_W-1:0] bytes,
                                 input logic [fbpa_pkg::COUNT_W-1:0] count);
      drain_pool();
      held_addrs.delete();
      write_csr(fbpa_pkg::CSR_POOL_BASE, base);
      write_csr(fbpa_pkg::CSR_BLOCK_BYTES, {16'($urandom), bytes});
      write_csr(fbpa_pkg::CSR_BLOCK_COUNT, {21'($urandom), count});
      settings_run++;
   endtask

   task automatic send_random_op();
      int unsigned                  r;
      int unsigned                  pick;
      logic [fbpa_pkg::ADDR_W-1:0]  addr;
      logic [fbpa_pkg::COUNT_W-1:0] cnt;
      r = $urandom_range(99);
      cnt = usable_blocks();
      pick = (cnt > 1) ? $urandom_range(32'(cnt) - 1) : 0;
      if (r < 45) begin
         send_req(fbpa_pkg::FUNC_ALLOC, $urandom);
      end else if (r < 80) begin
         if (held_addrs.size() != 0) begin
            pick = $urandom_range(held_addrs.size() - 1);
            addr = held_addrs[pick];
            held_addrs.delete(pick);
         end else begin
            addr = block_addr(pick);
         end
         send_req(fbpa_pkg::FUNC_FREE, addr);
      end else if (r < 85) begin
         send_req(fbpa_pkg::FUNC_FREE, block_addr(pick));
      end else if (r < 88) begin
         send_req(fbpa_pkg::FUNC_INIT, $urandom);
      end else if (r < 91) begin
         send_req(fbpa_pkg::FUNC_NOP, $urandom);
      end else if (r < 94) begin
         send_req(fbpa_pkg::FUNC_FREE, '0);
      end else if (r < 97) begin
         addr = (cfg_bytes > 1) ? block_addr(pick) + $urandom_range(32'(cfg_bytes) - 1, 1)
                                : $urandom;
         send_req(fbpa_pkg::FUNC_FREE, addr);
      end else begin
         send_req(fbpa_pkg::FUNC_FREE, $urandom);
      end
   endtask

   function automatic dir_row_type op_row(input logic [1:0] func,
                                          input logic [fbpa_pkg::ADDR_W-1:0] addr,
                                          input logic [fbpa_pkg::ADDR_W-1:0] grant,
                                          input logic [fbpa_pkg::STATUS_W-1:0] status);
      dir_row_type row;
      row.kind = ROW_OP;
      row.code = func;
      row.value = addr;
      row.typed = 1'b1;
      row.want.granted_address = grant;
      row.want.status = status;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [1:0] idx,
                                           input logic [fbpa_pkg::ADDR_W-1:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.code = idx;
      row.value = val;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   initial begin
      dir_row_type                  directed_rows [$];
      logic [fbpa_pkg::ADDR_W-1:0]  base;
      logic [fbpa_pkg::BYTES_W-1:0] bytes;
      logic [fbpa_pkg::COUNT_W-1:0] count;
      int waited;

      // reset settings: base 4096, 64-byte blocks, 1000 blocks
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'h0, fbpa_pkg::ST_EMPTY));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'h0, 32'h0, fbpa_pkg::ST_NULL));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_NOP, 32'hFFFF_FFFF, 32'h0,
                                     fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_INIT, 32'h0, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'd68032, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd68032, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'hAAAA_AAAA, 32'd68032,
                                     fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd4095, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd68096, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd68095, 32'h0,
                                     fbpa_pkg::ST_MISALIGNED));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd4096, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd4096, 32'h0, fbpa_pkg::ST_FULL));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFF, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'd4096, fbpa_pkg::ST_OK));
      // unused register index, then a count above capacity
      directed_rows.push_back(csr_row(CSR_UNUSED, 32'hDEAD_BEEF));
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_BLOCK_COUNT, 32'd2047));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_INIT, 32'h0, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd69632, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd69568, 32'h0,
                                     fbpa_pkg::ST_FULL));
      // zero block size
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_BLOCK_BYTES, 32'h0));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'd4096, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'd4096, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      // pool running past the top of the address space
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_POOL_BASE, 32'hFFFF_FFC0));
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_BLOCK_BYTES, 32'd64));
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_BLOCK_COUNT, 32'd4));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_INIT, 32'h0, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'h0000_0080,
                                     fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFC0, 32'h0,
                                     fbpa_pkg::ST_OK));
      // zero block count
      directed_rows.push_back(csr_row(fbpa_pkg::CSR_BLOCK_COUNT, 32'h0));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFC0, 32'h0,
                                     fbpa_pkg::ST_OUTSIDE));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_INIT, 32'h0, 32'h0, fbpa_pkg::ST_OK));
      directed_rows.push_back(op_row(fbpa_pkg::FUNC_ALLOC, 32'h0, 32'h0, fbpa_pkg::ST_EMPTY));

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_pool();
            write_csr(directed_rows[i].code, directed_rows[i].value);
         end else begin
            use_typed = directed_rows[i].typed;
            typed_want = directed_rows[i].want;
            send_req(directed_rows[i].code, directed_rows[i].value);
         end
      end
      use_typed = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               base = 32'd1;
               bytes = 16'd1;
               count = 11'd1;
            end
            1: begin
               base = 32'hFFFF_FFFF;
               bytes = 16'hFFFF;
               count = 11'd1024;
            end
            2: begin
               base = $urandom;
               bytes = 16'($urandom_range(64, 1));
               count = 11'($urandom_range(12, 2));
            end
            3: begin
               base = $urandom & 32'hFFFF_FFFC;
               bytes = 16'($urandom_range(65535, 1));
               count = 11'd2047;
            end
            4: begin
               base = 32'h0;
               bytes = 16'h0;
               count = 11'($urandom_range(8, 1));
            end
            5: begin
               base = $urandom;
               bytes = 16'($urandom_range(300, 1));
               count = 11'($urandom_range(20, 1));
            end
            6: begin
               base = $urandom;
               bytes = 16'd16;
               count = 11'd1000;
            end
            default: begin
               base = $urandom;
               bytes = 16'($urandom_range(65535, 1));
               count = 11'($urandom_range(40, 1));
            end
         endcase
         configure_pool(base, bytes, count);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 55;
            end
            default: begin
               send_idle_pct = 7;
               stall_pct = 7;
            end
         endcase
         send_req(fbpa_pkg::FUNC_INIT, $urandom);
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 100)
               hold_requests++;
            if (p == 3 && n == 125)
               drain_pool();
            send_random_op();
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (grant_queue.size() != 0 && waited < END_WAIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (grant_queue.size() != 0)
         report_mismatch("responses never delivered", grant_queue.size(), '0);

      $display("Run covered %0d items, %0d responses, %0d random pool settings",
               items_accepted, results_seen, settings_run);
      $display("Statuses: ok %0d empty %0d null %0d outside %0d misaligned %0d full %0d",
               status_seen[fbpa_pkg::ST_OK], status_seen[fbpa_pkg::ST_EMPTY],
               status_seen[fbpa_pkg::ST_NULL], status_seen[fbpa_pkg::ST_OUTSIDE],
               status_seen[fbpa_pkg::ST_MISALIGNED], status_seen[fbpa_pkg::ST_FULL]);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
